// File: rtl/pls_pkg.sv
package pls_pkg;

   // Widths that the cells share. A slot index covers the largest allowed list.
   localparam int SLOT_W = 8;
   localparam int LENF_W = SLOT_W + 1;
   localparam int DATA_W = 32;

   typedef enum logic [2:0] {
      KIND_ADD_LAST   = 3'd0,
      KIND_ADD_FIRST  = 3'd1,
      KIND_INSERT     = 3'd2,
      KIND_DROP_LAST  = 3'd3,
      KIND_DROP_FIRST = 3'd4,
      KIND_ERASE      = 3'd5,
      KIND_CLEAR      = 3'd6,
      KIND_COUNT      = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_EMPTY  = 2'd1,
      STATUS_FULL   = 2'd2,
      STATUS_BADPOS = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_OPEN,
      CELL_CLOSE,
      CELL_MATCH
   } cell_op_type;

   typedef enum logic {
      PLS_IDLE,
      PLS_COUNT
   } pls_state_type;

   typedef struct packed {
      cell_op_type         op;
      logic [SLOT_W-1:0]   slot;
      logic [LENF_W-1:0]   length;
      logic [DATA_W-1:0]   value;
   } cell_ctrl_type;

endpackage

// File: rtl/pls_if.sv
interface pls_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         kind;
   logic [4:0]         position;
   logic signed [31:0] item_value;

   modport source (output valid, output kind, output position, output item_value,
                   input ready);
   modport sink   (input valid, input kind, input position, input item_value,
                   output ready);
endinterface

interface pls_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [4:0] length;
   logic [4:0] match_count;

   modport source (output valid, output status, output length, output match_count,
                   input ready);
   modport sink   (input valid, input status, input length, input match_count,
                   output ready);
endinterface

// File: rtl/pls_cell.sv
module pls_cell
   import pls_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int SUM_W = 5
) (
   input  logic                clock,
   input  cell_ctrl_type       ctrl,
   input  logic [DATA_W-1:0]   left_data,
   input  logic [DATA_W-1:0]   right_data,
   output logic [DATA_W-1:0]   entry,
   input  logic [SUM_W-1:0]    sum_in,
   output logic [SUM_W-1:0]    sum_out
);

   localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(INDEX);
   localparam logic [LENF_W-1:0] MY_POS  = LENF_W'(INDEX);

   logic [DATA_W-1:0] entry_ff, entry_in;
   logic              match_ff, match_in;
   logic [SUM_W-1:0]  sum_ff, sum_in_w;

   always_comb begin
      entry_in = entry_ff;
      match_in = match_ff;
      unique case (ctrl.op)
         CELL_OPEN: begin
            if (MY_SLOT > ctrl.slot) begin
               entry_in = left_data;
            end else if (MY_SLOT == ctrl.slot) begin
               entry_in = ctrl.value;
            end
         end
         CELL_CLOSE: begin
            if (MY_SLOT >= ctrl.slot) begin
               entry_in = right_data;
            end
         end
         CELL_MATCH: begin
            match_in = (MY_POS < ctrl.length) && (entry_ff == ctrl.value);
         end
         default: begin
         end
      endcase
   end

   // Running match total ripples one cell further down the row every cycle.
   assign sum_in_w = sum_in + SUM_W'(match_ff);

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      match_ff <= match_in;
      sum_ff   <= sum_in_w;
   end

   assign entry   = entry_ff;
   assign sum_out = sum_ff;

endmodule

// File: rtl/positional_list_store.sv
// Channel   Dir  Fields                              Handshake
// req       in   kind, position, item_value          req.valid / req.ready
// rsp       out  status, length, match_count         rsp.valid / rsp.ready
//
// Every operation except count updates the row of cells in the cycle of the request
// and its response is registered at that edge, so it appears in the next cycle.
// A count latches one compare per cell, then the partial sums ripple through the row,
// one cell per cycle; the response then waits for a free output register.
// Reset (synchronous) empties the list; stored entries are not cleared.
// A new request is taken while a response waits, as long as no count is running and
// the output register is free or being emptied in the same cycle.
module positional_list_store
   import pls_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic       clock,
   input  logic       reset,
   pls_req_if.sink    req,
   pls_rsp_if.source  rsp
);

   localparam int LEN_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((LEN_W > 5) ? LEN_W : 5) + 1;
   localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

   pls_state_type     state_ff, state_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [4:0]        rsp_length_ff, rsp_length_in;
   logic [4:0]        rsp_match_ff, rsp_match_in;

   cell_ctrl_type     ctrl;
   logic              accept;
   logic              out_free;
   logic              load;
   logic [CMP_W-1:0]  pos_ext;
   logic [CMP_W-1:0]  len_ext;
   logic [31:0]       len_wide;
   logic [31:0]       sum_wide;
   logic [LEN_W-1:0]  len_after;

   logic [DATA_W-1:0] entry_w [CAPACITY];
   logic [LEN_W-1:0]  sum_w   [CAPACITY+1];

   assign sum_w[0] = '0;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_row
         logic [DATA_W-1:0] left_d;
         logic [DATA_W-1:0] right_d;
         if (gi == 0) begin : g_first
            assign left_d = ctrl.value;
         end else begin : g_left
            assign left_d = entry_w[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_last
            assign right_d = entry_w[gi];
         end else begin : g_right
            assign right_d = entry_w[gi+1];
         end
         pls_cell #(
            .INDEX (gi),
            .SUM_W (LEN_W)
         ) u_slot (
            .clock      (clock),
            .ctrl       (ctrl),
            .left_data  (left_d),
            .right_data (right_d),
            .entry      (entry_w[gi]),
            .sum_in     (sum_w[gi]),
            .sum_out    (sum_w[gi+1])
         );
      end
   endgenerate

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == PLS_IDLE) && out_free;
   assign accept    = req.valid && req.ready;
   assign pos_ext   = CMP_W'(req.position);
   assign len_ext   = CMP_W'(len_ff);
   assign sum_wide  = 32'(sum_w[CAPACITY]);

   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      cnt_in        = cnt_ff;
      load          = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_match_in  = rsp_match_ff;
      len_after     = len_ff;
      ctrl.op       = CELL_HOLD;
      ctrl.slot     = '0;
      ctrl.length   = LENF_W'(len_ff);
      ctrl.value    = req.item_value;

      unique case (state_ff)
         PLS_IDLE: begin
            if (accept) begin
               load          = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_match_in  = '0;
               unique case (kind_type'(req.kind))
                  KIND_ADD_LAST, KIND_ADD_FIRST: begin
                     if (len_ff == CAP_LEN) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        ctrl.op   = CELL_OPEN;
                        ctrl.slot = (kind_type'(req.kind) == KIND_ADD_LAST) ?
                                    SLOT_W'(len_ff) : '0;
                        len_after = len_ff + 1'b1;
                     end
                  end
                  KIND_INSERT: begin
                     if (len_ff == CAP_LEN) begin
                        rsp_status_in = STATUS_FULL;
                     end else if (pos_ext == '0 || pos_ext > len_ext + 1'b1) begin
                        rsp_status_in = STATUS_BADPOS;
                     end else begin
                        ctrl.op   = CELL_OPEN;
                        ctrl.slot = SLOT_W'(pos_ext - 1'b1);
                        len_after = len_ff + 1'b1;
                     end
                  end
                  KIND_DROP_LAST, KIND_DROP_FIRST: begin
                     if (len_ff == '0) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        ctrl.op   = CELL_CLOSE;
                        ctrl.slot = (kind_type'(req.kind) == KIND_DROP_LAST) ?
                                    SLOT_W'(len_ff - 1'b1) : '0;
                        len_after = len_ff - 1'b1;
                     end
                  end
                  KIND_ERASE: begin
                     if (len_ff == '0) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else if (pos_ext == '0 || pos_ext > len_ext) begin
                        rsp_status_in = STATUS_BADPOS;
                     end else begin
                        ctrl.op   = CELL_CLOSE;
                        ctrl.slot = SLOT_W'(pos_ext - 1'b1);
                        len_after = len_ff - 1'b1;
                     end
                  end
                  KIND_CLEAR: begin
                     len_after = '0;
                  end
                  KIND_COUNT: begin
                     // The result waits until the sums have rippled to the last cell.
                     load     = 1'b0;
                     ctrl.op  = CELL_MATCH;
                     cnt_in   = CAP_LEN;
                     state_in = PLS_COUNT;
                  end
                  default: begin
                  end
               endcase
               len_in = len_after;
            end
         end
         PLS_COUNT: begin
            if (cnt_ff != '0) begin
               cnt_in = cnt_ff - 1'b1;
            end else if (out_free) begin
               load          = 1'b1;
               rsp_status_in = STATUS_OK;
               rsp_match_in  = sum_wide[4:0];
               state_in      = PLS_IDLE;
            end
         end
         default: begin
            state_in = PLS_IDLE;
         end
      endcase

      len_wide      = 32'(len_after);
      rsp_length_in = load ? len_wide[4:0] : rsp_length_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= PLS_IDLE;
         len_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_length_ff <= rsp_length_in;
      rsp_match_ff  <= rsp_match_in;
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.length      = rsp_length_ff;
   assign rsp.match_count = rsp_match_ff;

`ifndef SYNTHESIS
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      len_ff <= CAP_LEN)
      else $error("list length exceeds capacity");

   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == PLS_COUNT |-> !req.ready)
      else $error("request taken during a count");

   a_quick_rsp: assert property (@(posedge clock) disable iff (reset)
      accept && req.kind != KIND_COUNT |=> rsp.valid)
      else $error("missing response after a one-cycle request");

   a_count_start: assert property (@(posedge clock) disable iff (reset)
      accept && req.kind == KIND_COUNT |=> state_ff == PLS_COUNT && cnt_ff == CAP_LEN)
      else $error("count did not start its sweep");
`endif

endmodule

// File: test/tb_positional_list_store.sv
`timescale 1ns / 100ps

module tb_positional_list_store;
   import pls_pkg::*;

   localparam int CAPACITY    = 16;
   localparam int STALL_LIMIT = 2000;
   localparam int RANDOM_REQS = 1250;

   typedef struct packed {
      status_type  status;
      logic [4:0]  length;
      logic [4:0]  match_count;
   } reply_type;

   typedef struct packed {
      kind_type           kind;
      logic [4:0]         position;
      logic signed [31:0] item_value;
      int                 reps;
      bit                 typed;
      reply_type          reply;
   } script_row_type;

   localparam int SCRIPT_ROWS = 29;

   // Rows with typed set carry a reply that is plain from the list contents; the rest
   // take theirs from the list predictor. The run of sixteen appends fills the list
   // to capacity.
   localparam script_row_type SCRIPT [SCRIPT_ROWS] = '{
      '{KIND_DROP_LAST,  5'd0,  32'sd0,          1,  1'b1, '{STATUS_EMPTY,  5'd0,  5'd0}},
      '{KIND_DROP_FIRST, 5'd0,  32'sd0,          1,  1'b1, '{STATUS_EMPTY,  5'd0,  5'd0}},
      '{KIND_ERASE,      5'd1,  32'sd0,          1,  1'b1, '{STATUS_EMPTY,  5'd0,  5'd0}},
      '{KIND_INSERT,     5'd2,  32'sd1,          1,  1'b1, '{STATUS_BADPOS, 5'd0,  5'd0}},
      '{KIND_INSERT,     5'd0,  32'sd1,          1,  1'b1, '{STATUS_BADPOS, 5'd0,  5'd0}},
      '{KIND_COUNT,      5'd0,  32'sd0,          1,  1'b1, '{STATUS_OK,     5'd0,  5'd0}},
      '{KIND_INSERT,     5'd1,  32'sh80000000,   1,  1'b1, '{STATUS_OK,     5'd1,  5'd0}},
      '{KIND_DROP_LAST,  5'd0,  32'sd0,          1,  1'b1, '{STATUS_OK,     5'd0,  5'd0}},
      '{KIND_ADD_LAST,   5'd0,  32'sh7fffffff,   1,  1'b1, '{STATUS_OK,     5'd1,  5'd0}},
      '{KIND_ADD_FIRST,  5'd0,  32'sh80000000,   1,  1'b1, '{STATUS_OK,     5'd2,  5'd0}},
      '{KIND_INSERT,     5'd3,  -32'sd1,         1,  1'b0, '{STATUS_OK,     5'd0,  5'd0}},
      '{KIND_INSERT,     5'd1,  32'sd0,          1,  1'b0, '{STATUS_OK,     5'd0,  5'd0}},
      '{KIND_ERASE,      5'd5,  32'sd0,          1,  1'b1, '{STATUS_BADPOS, 5'd4,  5'd0}},
      '{KIND_ERASE,      5'd1,  32'sd0,          1,  1'b0, '{STATUS_OK,     5'd0,  5'd0}},
      '{KIND_COUNT,      5'd0,  -32'sd1,         1,  1'b0, '{STATUS_OK,     5'd0,  5'd0}},
      '{KIND_DROP_FIRST, 5'd0,  32'sd0,          1,  1'b0, '{STATUS_OK,     5'd0,  5'd0}},
      '{KIND_ERASE,      5'd31, 32'sd0,          1,  1'b1, '{STATUS_BADPOS, 5'd2,  5'd0}},
      '{KIND_CLEAR,      5'd0,  32'sd0,          1,  1'b1, '{STATUS_OK,     5'd0,  5'd0}},
      '{KIND_ADD_LAST,   5'd0,  32'sh5a5a5a5a,   16, 1'b0, '{STATUS_OK,     5'd0,  5'd0}},
      '{KIND_ADD_LAST,   5'd0,  32'sd1,          1,  1'b1, '{STATUS_FULL,   5'd16, 5'd0}},
      '{KIND_ADD_FIRST,  5'd0,  32'sd1,          1,  1'b1, '{STATUS_FULL,   5'd16, 5'd0}},
      '{KIND_INSERT,     5'd17, 32'sd1,          1,  1'b1, '{STATUS_FULL,   5'd16, 5'd0}},
      '{KIND_INSERT,     5'd0,  32'sd1,          1,  1'b1, '{STATUS_FULL,   5'd16, 5'd0}},
      '{KIND_COUNT,      5'd0,  32'sh5a5a5a5a,   1,  1'b1, '{STATUS_OK,     5'd16, 5'd16}},
      '{KIND_ERASE,      5'd16, 32'sd0,          1,  1'b0, '{STATUS_OK,     5'd0,  5'd0}},
      '{KIND_ERASE,      5'd16, 32'sd0,          1,  1'b1, '{STATUS_BADPOS, 5'd15, 5'd0}},
      '{KIND_INSERT,     5'd16, 32'sd7,          1,  1'b0, '{STATUS_OK,     5'd0,  5'd0}},
      '{KIND_COUNT,      5'd0,  32'sd7,          1,  1'b1, '{STATUS_OK,     5'd16, 5'd1}},
      '{KIND_CLEAR,      5'd0,  32'sd0,          1,  1'b1, '{STATUS_OK,     5'd0,  5'd0}}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   pls_req_if req_bus ();
   pls_rsp_if rsp_bus ();

   positional_list_store #(
      .CAPACITY (CAPACITY)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   logic signed [31:0] shadow_list [$];
   reply_type          pending_replies [$];
   logic signed [31:0] value_pool [8];
   int                 errors = 0;
   int                 quiet_cycles = 0;
   bit                 req_steady = 1'b0;
   bit                 rsp_steady = 1'b0;

   // Applies one request to the shadow list and returns the reply it should produce.
   function automatic reply_type list_apply(kind_type k, logic [4:0] pos,
                                            logic signed [31:0] v);
      reply_type r;
      int        n;
      int        p;
      int        hits;
      r.status = STATUS_OK;
      n        = shadow_list.size();
      p        = int'(pos);
      hits     = 0;
      case (k)
         KIND_ADD_LAST, KIND_ADD_FIRST: begin
            if (n >= CAPACITY)
               r.status = STATUS_FULL;
            else if (k == KIND_ADD_LAST)
               shadow_list.insert(n, v);
            else
               shadow_list.insert(0, v);
         end
         KIND_INSERT: begin
            if (n >= CAPACITY)
               r.status = STATUS_FULL;
            else if (p < 1 || p > n + 1)
               r.status = STATUS_BADPOS;
            else
               shadow_list.insert(p - 1, v);
         end
         KIND_DROP_LAST, KIND_DROP_FIRST: begin
            if (n == 0)
               r.status = STATUS_EMPTY;
            else if (k == KIND_DROP_LAST)
               shadow_list.delete(n - 1);
            else
               shadow_list.delete(0);
         end
         KIND_ERASE: begin
            if (n == 0)
               r.status = STATUS_EMPTY;
            else if (p < 1 || p > n)
               r.status = STATUS_BADPOS;
            else
               shadow_list.delete(p - 1);
         end
         KIND_CLEAR: begin
            shadow_list.delete();
         end
         default: begin
            foreach (shadow_list[i])
               if (shadow_list[i] == v)
                  hits++;
         end
      endcase
      r.length      = 5'(shadow_list.size());
      r.match_count = 5'(hits);
      return r;
   endfunction

   // Mostly short pauses, now and then a long one, none at all in a steady stretch.
   function automatic int pause_cycles(bit steady);
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 30);
   endfunction

   task automatic send_request(kind_type k, logic [4:0] pos, logic signed [31:0] v,
                               bit typed, reply_type fixed);
      reply_type guess;
      int        gap;
      req_bus.valid      <= 1'b1;
      req_bus.kind       <= k;
      req_bus.position   <= pos;
      req_bus.item_value <= v;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      guess = list_apply(k, pos, v);
      pending_replies.insert(pending_replies.size(), typed ? fixed : guess);
      gap = pause_cycles(req_steady);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_random_request();
      kind_type           k;
      logic [4:0]         pos;
      logic signed [31:0] v;
      int                 n;
      int                 r;
      bit                 grow;
      n = shadow_list.size();
      r = $urandom_range(0, 99);
      // Lean toward growth when the list is short so both full and empty are visited.
      grow = ($urandom_range(0, 99) < (n < CAPACITY / 2 ? 70 : 35));
      if (r < 2)
         k = KIND_CLEAR;
      else if (r < 14)
         k = KIND_COUNT;
      else if (grow)
         k = kind_type'($urandom_range(0, 2));
      else
         k = kind_type'($urandom_range(3, 5));
      if ($urandom_range(0, 99) < 15)
         pos = 5'($urandom_range(0, 31));
      else if (k == KIND_ERASE)
         pos = 5'($urandom_range(1, n > 0 ? n : 1));
      else
         pos = 5'($urandom_range(1, n + 1));
      // A small pool of repeated values gives count something to find.
      if ($urandom_range(0, 2) == 0)
         v = $urandom;
      else
         v = value_pool[$urandom_range(0, 7)];
      send_request(k, pos, v, 1'b0, '0);
   endtask

   always @(posedge clock) begin
      reply_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_replies.size() == 0) begin
            $error("reply with no request outstanding: status %0d length %0d match_count %0d",
                   rsp_bus.status, rsp_bus.length, rsp_bus.match_count);
            errors++;
         end else begin
            want = pending_replies[0];
            pending_replies.delete(0);
            if (rsp_bus.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
               errors++;
            end
            if (rsp_bus.length !== want.length) begin
               $error("length: expected %0d, got %0d", want.length, rsp_bus.length);
               errors++;
            end
            if (rsp_bus.match_count !== want.match_count) begin
               $error("match_count: expected %0d, got %0d", want.match_count,
                      rsp_bus.match_count);
               errors++;
            end
         end
      end
   end

   initial begin : reply_pacing
      int stall_left;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 199) == 0)
            rsp_steady = ~rsp_steady;
         if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 2) == 0)
               stall_left = pause_cycles(rsp_steady);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin : stimulus
      req_bus.valid      <= 1'b0;
      req_bus.kind       <= KIND_ADD_LAST;
      req_bus.position   <= '0;
      req_bus.item_value <= '0;
      foreach (value_pool[i])
         value_pool[i] = $urandom;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (SCRIPT[row])
         repeat (SCRIPT[row].reps)
            send_request(SCRIPT[row].kind, SCRIPT[row].position, SCRIPT[row].item_value,
                         SCRIPT[row].typed, SCRIPT[row].reply);

      for (int i = 0; i < RANDOM_REQS; i++) begin
         if (i % 100 == 0)
            req_steady = ($urandom_range(0, 3) == 0);
         send_random_request();
      end
      req_bus.valid <= 1'b0;

      while (pending_replies.size() != 0)
         @(posedge clock);
      repeat (CAPACITY + 8) @(posedge clock);
      if (errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
